// ===== rtl/core/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, widths and the arctangent table for the Euler-angle to
// quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // Output scaling: 2^OUT_FRAC_BITS equals 1.0.
  localparam int OUT_FRAC_BITS = 14;
  // Number of CORDIC iterations, one pipeline stage each.
  localparam int CORDIC_STEPS  = 16;

  localparam int ANG_W   = 16;
  localparam int OUT_W   = 16;
  localparam int RES_W   = 14;
  localparam int TRIG_W  = 34;
  localparam int Z_W     = 33;
  localparam int PAIR_W  = 36;
  localparam int PROD_W  = PAIR_W + TRIG_W;
  localparam int SUM_W   = 72;
  localparam int ROUND_SH = 60 - OUT_FRAC_BITS;

  // One full turn of the half angle and one quadrant, in 1/128 degree.
  localparam int HALF_TURN_FULL   = 46080;
  localparam int QUARTER_UNITS    = 11520;
  localparam int RAD_PER_UNIT_Q30 = 146409;
  localparam int INV_GAIN_Q30     = 652032874;

  // Total register stages from input transfer to output register.
  localparam int LATENCY = CORDIC_STEPS + 6;

  // Quadrant codes of the reduced half angle.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef logic signed [TRIG_W-1:0] trig_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      24: v = 32'd64;
      25: v = 32'd32;
      26: v = 32'd16;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/e2q_if.sv =====
// ----------------------------------------------------------------------------
// e2q_in_if / e2q_out_if
// Valid/ready channels carrying the angle set and the quaternion.
// ----------------------------------------------------------------------------
interface e2q_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [e2q_pkg::ANG_W-1:0]      roll_deg;
  logic signed [e2q_pkg::ANG_W-1:0]      pitch_deg;
  logic signed [e2q_pkg::ANG_W-1:0]      yaw_deg;

  modport source(output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink(input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

interface e2q_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [e2q_pkg::OUT_W-1:0]      w_part;
  logic signed [e2q_pkg::OUT_W-1:0]      x_part;
  logic signed [e2q_pkg::OUT_W-1:0]      y_part;
  logic signed [e2q_pkg::OUT_W-1:0]      z_part;

  modport source(output valid, w_part, x_part, y_part, z_part, input ready);
  modport sink(input valid, w_part, x_part, y_part, z_part, output ready);
endinterface

// ===== rtl/core/e2q_trig.sv =====
// ----------------------------------------------------------------------------
// e2q_trig
// Pipelined cosine and sine of one half angle: range reduction, conversion
// to radians, one CORDIC iteration per stage and quadrant correction.
// ----------------------------------------------------------------------------
module e2q_trig (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2q_pkg::ANG_W-1:0]  angle,
  output e2q_pkg::trig_t                    cos_q,
  output e2q_pkg::trig_t                    sin_q
);

  localparam int N = e2q_pkg::CORDIC_STEPS;

  logic signed [e2q_pkg::ANG_W:0]  h_ext;
  logic signed [e2q_pkg::ANG_W:0]  m_full;
  logic [e2q_pkg::ANG_W-1:0]       m_val;
  e2q_pkg::quad_t                  quad_nxt;
  logic [e2q_pkg::ANG_W-1:0]       base_nxt;
  logic [e2q_pkg::RES_W-1:0]       res_nxt;

  logic [e2q_pkg::RES_W-1:0]       res_r;
  e2q_pkg::quad_t                  quad1_r;

  e2q_pkg::trig_t                  x_r [0:N];
  e2q_pkg::trig_t                  y_r [0:N];
  logic signed [e2q_pkg::Z_W-1:0]  z_r [0:N];
  e2q_pkg::quad_t                  quad_r [0:N];

  e2q_pkg::trig_t                  cos_r;
  e2q_pkg::trig_t                  sin_r;

  // Wrap the half angle into one turn and split off the quadrant.
  always_comb begin
    h_ext  = (e2q_pkg::ANG_W+1)'(angle);
    m_full = h_ext[e2q_pkg::ANG_W] ?
             h_ext + (e2q_pkg::ANG_W+1)'(e2q_pkg::HALF_TURN_FULL) : h_ext;
    m_val  = m_full[e2q_pkg::ANG_W-1:0];
    priority if (m_val >= e2q_pkg::ANG_W'(3 * e2q_pkg::QUARTER_UNITS)) begin
      quad_nxt = e2q_pkg::QUAD_3;
      base_nxt = e2q_pkg::ANG_W'(3 * e2q_pkg::QUARTER_UNITS);
    end else if (m_val >= e2q_pkg::ANG_W'(2 * e2q_pkg::QUARTER_UNITS)) begin
      quad_nxt = e2q_pkg::QUAD_2;
      base_nxt = e2q_pkg::ANG_W'(2 * e2q_pkg::QUARTER_UNITS);
    end else if (m_val >= e2q_pkg::ANG_W'(e2q_pkg::QUARTER_UNITS)) begin
      quad_nxt = e2q_pkg::QUAD_1;
      base_nxt = e2q_pkg::ANG_W'(e2q_pkg::QUARTER_UNITS);
    end else begin
      quad_nxt = e2q_pkg::QUAD_0;
      base_nxt = '0;
    end
    res_nxt = e2q_pkg::RES_W'(m_val - base_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r   <= res_nxt;
      quad1_r <= quad_nxt;
    end
  end

  // Residue to radians in Q30; the CORDIC starts from 1/gain on the x axis.
  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]    <= e2q_pkg::Z_W'(e2q_pkg::Z_W'(res_r) *
                                 e2q_pkg::Z_W'(e2q_pkg::RAD_PER_UNIT_Q30));
      x_r[0]    <= e2q_pkg::TRIG_W'(e2q_pkg::INV_GAIN_Q30);
      y_r[0]    <= '0;
      quad_r[0] <= quad1_r;
    end
  end

  // One rotation step per stage, direction chosen by the sign of z.
  for (genvar g = 0; g < N; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[g][e2q_pkg::Z_W-1]) begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - e2q_pkg::Z_W'(e2q_pkg::atan_q30(g));
        end else begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + e2q_pkg::Z_W'(e2q_pkg::atan_q30(g));
        end
        quad_r[g+1] <= quad_r[g];
      end
    end
  end

  // Rotate the result back into its quadrant.
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (quad_r[N])
        e2q_pkg::QUAD_1: begin
          cos_r <= -y_r[N];
          sin_r <= x_r[N];
        end
        e2q_pkg::QUAD_2: begin
          cos_r <= -x_r[N];
          sin_r <= -y_r[N];
        end
        e2q_pkg::QUAD_3: begin
          cos_r <= y_r[N];
          sin_r <= -x_r[N];
        end
        default: begin
          cos_r <= x_r[N];
          sin_r <= y_r[N];
        end
      endcase
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

// ===== rtl/core/e2q_combine.sv =====
// ----------------------------------------------------------------------------
// e2q_combine
// Forms the ZYX quaternion from six half-angle cosines and sines in three
// stages: pair products, component products, then sum, round and saturate.
// ----------------------------------------------------------------------------
module e2q_combine (
  input  logic                              clk,
  input  logic                              en,
  input  e2q_pkg::trig_t                    cr,
  input  e2q_pkg::trig_t                    sr,
  input  e2q_pkg::trig_t                    cp,
  input  e2q_pkg::trig_t                    sp,
  input  e2q_pkg::trig_t                    cy,
  input  e2q_pkg::trig_t                    sy,
  output logic signed [e2q_pkg::OUT_W-1:0]  w_q,
  output logic signed [e2q_pkg::OUT_W-1:0]  x_q,
  output logic signed [e2q_pkg::OUT_W-1:0]  y_q,
  output logic signed [e2q_pkg::OUT_W-1:0]  z_q
);

  localparam int PW = 2 * e2q_pkg::TRIG_W;

  logic signed [e2q_pkg::PAIR_W-1:0] cycp_r, sysp_r, sycp_r, cysp_r;
  e2q_pkg::trig_t                    cr_r, sr_r;
  logic signed [e2q_pkg::PROD_W-1:0] p_r [0:7];
  logic signed [e2q_pkg::OUT_W-1:0]  w_r, x_r, y_r, z_r;
  logic signed [e2q_pkg::SUM_W-1:0]  sum_w, sum_x, sum_y, sum_z;

  // Q30 times Q30 with rounding back to Q30.
  function automatic logic signed [e2q_pkg::PAIR_W-1:0] mul_q30(
    input e2q_pkg::trig_t a, input e2q_pkg::trig_t b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b)) + PW'(64'sd1 <<< 29);
    p = p >>> 30;
    return p[e2q_pkg::PAIR_W-1:0];
  endfunction

  // Round half up to the output scale and clamp to plus or minus one.
  function automatic logic signed [e2q_pkg::OUT_W-1:0] finish(
    input logic signed [e2q_pkg::SUM_W-1:0] s);
    logic signed [e2q_pkg::SUM_W-1:0] v;
    logic signed [e2q_pkg::SUM_W-1:0] lim;
    v   = (s + (e2q_pkg::SUM_W'(1) <<< (e2q_pkg::ROUND_SH - 1))) >>> e2q_pkg::ROUND_SH;
    lim = e2q_pkg::SUM_W'(1) <<< e2q_pkg::OUT_FRAC_BITS;
    if (v > lim) begin
      v = lim;
    end
    if (v < -lim) begin
      v = -lim;
    end
    return v[e2q_pkg::OUT_W-1:0];
  endfunction

  // Yaw-pitch pair products; roll terms wait one stage beside them.
  always_ff @(posedge clk) begin
    if (en) begin
      cycp_r <= mul_q30(cy, cp);
      sysp_r <= mul_q30(sy, sp);
      sycp_r <= mul_q30(sy, cp);
      cysp_r <= mul_q30(cy, sp);
      cr_r   <= cr;
      sr_r   <= sr;
    end
  end

  // Eight products of a pair with a roll term.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= e2q_pkg::PROD_W'(cycp_r) * e2q_pkg::PROD_W'(cr_r);
      p_r[1] <= e2q_pkg::PROD_W'(sysp_r) * e2q_pkg::PROD_W'(sr_r);
      p_r[2] <= e2q_pkg::PROD_W'(cycp_r) * e2q_pkg::PROD_W'(sr_r);
      p_r[3] <= e2q_pkg::PROD_W'(sysp_r) * e2q_pkg::PROD_W'(cr_r);
      p_r[4] <= e2q_pkg::PROD_W'(sycp_r) * e2q_pkg::PROD_W'(sr_r);
      p_r[5] <= e2q_pkg::PROD_W'(cysp_r) * e2q_pkg::PROD_W'(cr_r);
      p_r[6] <= e2q_pkg::PROD_W'(sycp_r) * e2q_pkg::PROD_W'(cr_r);
      p_r[7] <= e2q_pkg::PROD_W'(cysp_r) * e2q_pkg::PROD_W'(sr_r);
    end
  end

  // Component sums in Q60.
  always_comb begin
    sum_w = e2q_pkg::SUM_W'(p_r[0]) + e2q_pkg::SUM_W'(p_r[1]);
    sum_x = e2q_pkg::SUM_W'(p_r[2]) - e2q_pkg::SUM_W'(p_r[3]);
    sum_y = e2q_pkg::SUM_W'(p_r[4]) + e2q_pkg::SUM_W'(p_r[5]);
    sum_z = e2q_pkg::SUM_W'(p_r[6]) - e2q_pkg::SUM_W'(p_r[7]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= finish(sum_w);
      x_r <= finish(sum_x);
      y_r <= finish(sum_y);
      z_r <= finish(sum_z);
    end
  end

  assign w_q = w_r;
  assign x_q = x_r;
  assign y_q = y_r;
  assign z_q = z_r;

endmodule

// ===== rtl/core/euler_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Converts roll, pitch and yaw angles to the unit quaternion of the ZYX
// rotation through a fully pipelined CORDIC and multiplier chain.
// ----------------------------------------------------------------------------
// The block accepts one angle set per clock cycle while the pipeline
// advances. Two stages reduce each half angle and convert it to radians,
// one stage per CORDIC iteration, one stage for the quadrant correction,
// and three for the products, rounding and saturation. All stages advance
// together; when the output register holds an untaken result the whole
// pipeline holds, and the input is ready again in the cycle that result
// is transferred.
module euler_to_quaternion (
  input  logic        clk,
  input  logic        rst_n,
  e2q_in_if.sink      in_chan,
  e2q_out_if.source   out_chan
);

  localparam int L = e2q_pkg::LATENCY;

  logic           adv;
  logic [L-1:0]   vld_r;
  logic [L-1:0]   vld_nxt;

  e2q_pkg::trig_t cr, sr, cp, sp, cy, sy;

  // Pipeline advances unless a finished result at the output is not taken.
  assign adv            = !vld_r[L-1] || out_chan.ready;
  assign in_chan.ready  = adv;
  assign out_chan.valid = vld_r[L-1];

  // Valid bits move alongside the data.
  always_comb begin
    vld_nxt = {vld_r[L-2:0], in_chan.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  e2q_trig u_roll (
    .clk   (clk),
    .en    (adv),
    .angle (in_chan.roll_deg),
    .cos_q (cr),
    .sin_q (sr)
  );

  e2q_trig u_pitch (
    .clk   (clk),
    .en    (adv),
    .angle (in_chan.pitch_deg),
    .cos_q (cp),
    .sin_q (sp)
  );

  e2q_trig u_yaw (
    .clk   (clk),
    .en    (adv),
    .angle (in_chan.yaw_deg),
    .cos_q (cy),
    .sin_q (sy)
  );

  e2q_combine u_combine (
    .clk (clk),
    .en  (adv),
    .cr  (cr),
    .sr  (sr),
    .cp  (cp),
    .sp  (sp),
    .cy  (cy),
    .sy  (sy),
    .w_q (out_chan.w_part),
    .x_q (out_chan.x_part),
    .y_q (out_chan.y_part),
    .z_q (out_chan.z_part)
  );

endmodule

// ===== sim/e2q_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel notes
// The valid/ready channels come from the RTL interface file; this file holds
// the transfer record types that the testbench queues carry.
// ----------------------------------------------------------------------------
package e2q_tb_types_pkg;

  // One angle set as sent on the input channel.
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angle_set_t;

  // One quaternion as expected on the result channel.
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

endpackage

// ===== sim/tb_euler_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion
// Drives angle sets into the Euler-to-quaternion converter, predicts each
// quaternion with a bit-exact CORDIC model and compares every output transfer
// in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_euler_to_quaternion;
  import e2q_pkg::*;
  import e2q_tb_types_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    longint c;
    longint s;
  } cos_sin_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  e2q_in_if  in_chan();
  e2q_out_if out_chan();

  euler_to_quaternion u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  angle_set_t angle_queue[$];
  quat_t      quat_queue[$];
  int         fail_count = 0;
  int         cycle_count = 0;
  bit         calm_phase = 1'b0;
  bit         hold_sender = 1'b0;
  int         send_gap = 0;
  int         recv_gap = 0;

  // Arctangent of 2^-i in Q30.
  function automatic longint atan_entry(int i);
    longint tbl[32] = '{843314857, 497837829, 263043837, 133525159,
                        67021687, 33543516, 16775851, 8388437,
                        4194283, 2097149, 1048576, 524288,
                        262144, 131072, 65536, 32768,
                        16384, 8192, 4096, 2048, 1024, 512, 256, 128,
                        64, 32, 16, 8, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // Cosine and sine of a half angle given in 1/128 degree.
  function automatic cos_sin_t half_cos_sin(logic signed [15:0] raw);
    longint   m;
    longint   quad;
    longint   cx;
    longint   cy;
    longint   cz;
    longint   nx;
    cos_sin_t r;
    m = longint'(raw) % HALF_TURN_FULL;
    if (m < 0) m += HALF_TURN_FULL;
    quad = m / QUARTER_UNITS;
    cz = (m % QUARTER_UNITS) * longint'(RAD_PER_UNIT_Q30);
    cx = INV_GAIN_Q30;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz -= atan_entry(i);
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz += atan_entry(i);
      end
      cx = nx;
    end
    case (quad)
      1:       begin r.c = -cy; r.s = cx;  end
      2:       begin r.c = -cx; r.s = -cy; end
      3:       begin r.c = cy;  r.s = -cx; end
      default: begin r.c = cx;  r.s = cy;  end
    endcase
    return r;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  // Rounds a Q60 sum to the output scale and saturates it.
  function automatic logic signed [15:0] round_sat(longint q60);
    longint v;
    longint lim;
    lim = longint'(1) << OUT_FRAC_BITS;
    v = (q60 + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic quat_t zyx_quaternion(angle_set_t a);
    cos_sin_t r;
    cos_sin_t p;
    cos_sin_t y;
    longint   cycp;
    longint   sysp;
    longint   sycp;
    longint   cysp;
    quat_t    q;
    r = half_cos_sin(a.roll);
    p = half_cos_sin(a.pitch);
    y = half_cos_sin(a.yaw);
    cycp = mul_q30(y.c, p.c);
    sysp = mul_q30(y.s, p.s);
    sycp = mul_q30(y.s, p.c);
    cysp = mul_q30(y.c, p.s);
    q.w = round_sat(cycp * r.c + sysp * r.s);
    q.x = round_sat(cycp * r.s - sysp * r.c);
    q.y = round_sat(sycp * r.s + cysp * r.c);
    q.z = round_sat(sycp * r.c - cysp * r.s);
    return q;
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(0, 46080)) - 23040);
      2:       return 16'($signed($urandom_range(0, 8)) * 2880 - 11520);
      default: return 16'($signed($urandom_range(0, 1600)) - 800);
    endcase
  endfunction

  // Fill the stimulus queue: directed corners first, then random sets.
  initial begin
    logic signed [15:0] corners[12] = '{16'sd0, 16'sd23040, -16'sd23040,
      16'sd32767, -16'sd32768, 16'sd11520, -16'sd11520, 16'sd5760,
      16'sd11519, 16'sd34560, -16'sd1, 16'sd1};
    foreach (corners[i])
      angle_queue.push_back('{corners[i], corners[(i + 3) % 12], corners[(i + 7) % 12]});
    angle_queue.push_back('{16'sd0, 16'sd0, 16'sd0});
    angle_queue.push_back('{16'sd5760, 16'sd5760, 16'sd5760});
    angle_queue.push_back('{-16'sd32768, 16'sd32767, -16'sd32768});
    angle_queue.push_back('{16'sd0, 16'sd11520, 16'sd0});
    angle_queue.push_back('{16'sd23040, -16'sd23040, 16'sd11520});
    angle_queue.push_back('{16'sd17280, 16'sd28800, -16'sd5760});
    for (int n = 0; n < 900; n++)
      angle_queue.push_back('{rand_angle(), rand_angle(), rand_angle()});
  end

  // Reset, then pause the sender once until the pipeline drains, then stop random idling.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (angle_queue.size() < 500);
    @(posedge clk);
    hold_sender <= 1'b1;
    wait (quat_queue.size() == 0);
    @(posedge clk);
    hold_sender <= 1'b0;
    wait (angle_queue.size() < 120);
    calm_phase <= 1'b1;
  end

  // Input driver: presents the head of the queue with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid     <= 1'b0;
      in_chan.roll_deg  <= '0;
      in_chan.pitch_deg <= '0;
      in_chan.yaw_deg   <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        quat_queue.push_back(zyx_quaternion('{in_chan.roll_deg, in_chan.pitch_deg,
                                              in_chan.yaw_deg}));
        void'(angle_queue.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_chan.valid <= 1'b0;
      end else if (!calm_phase && !(in_chan.valid && !in_chan.ready) &&
                   $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 18) - 1;
        in_chan.valid <= 1'b0;
      end else if (!hold_sender && angle_queue.size() > 0 &&
                   !(in_chan.valid && in_chan.ready && angle_queue.size() == 0)) begin
        in_chan.valid     <= 1'b1;
        in_chan.roll_deg  <= angle_queue[0].roll;
        in_chan.pitch_deg <= angle_queue[0].pitch;
        in_chan.yaw_deg   <= angle_queue[0].yaw;
      end else if (!(in_chan.valid && !in_chan.ready)) begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Output monitor: random stalls and an in-order compare of each transfer.
  always @(posedge clk) begin
    quat_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (quat_queue.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          want = quat_queue.pop_front();
          if (out_chan.w_part !== want.w) begin
            $error("w_part expected %0d got %0d", want.w, out_chan.w_part);
            fail_count++;
          end
          if (out_chan.x_part !== want.x) begin
            $error("x_part expected %0d got %0d", want.x, out_chan.x_part);
            fail_count++;
          end
          if (out_chan.y_part !== want.y) begin
            $error("y_part expected %0d got %0d", want.y, out_chan.y_part);
            fail_count++;
          end
          if (out_chan.z_part !== want.z) begin
            $error("z_part expected %0d got %0d", want.z, out_chan.z_part);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_chan.ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 18) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Cycle limit guards against a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // End of run: all sets sent, all results back, then a latency tail.
  initial begin
    wait (rst_n);
    wait (angle_queue.size() == 0 && quat_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && quat_queue.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/e2q_pkg.sv
rtl/core/e2q_if.sv
rtl/core/e2q_trig.sv
rtl/core/e2q_combine.sv
rtl/core/euler_to_quaternion.sv
sim/e2q_tb_if.sv
sim/tb_euler_to_quaternion.sv
